// ===== rtl/core/spl_pkg.sv =====
// spl_pkg: shared constants and types of the stereo peak limiter
// no dependencies; compiled first

package spl_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int COEFF_FRAC_BITS_DEF = 24;

    // register reset values, given in Q3.20 / Q0.24
    localparam int unsigned CEIL_RESET_Q20    = 943718;
    localparam int unsigned ATTACK_RESET_Q24  = 16603361;
    localparam int unsigned RELEASE_RESET_Q24 = 16775468;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CEILING = 2'd0,
        REG_ATTACK  = 2'd1,
        REG_RELEASE = 2'd2
    } t_reg_idx;

    // per-item classification made by the front
    typedef struct packed {
        logic neg_l;
        logic neg_r;
        logic last;
        logic over;
    } t_work_flags;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/spl_in_if.sv =====
// spl_in_if: input channel of the limiter, one stereo sample pair per transfer
// depends on spl_pkg

interface spl_in_if
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_last;

    modport source (output valid, output left_in, output right_in, output block_last,
                    input ready);
    modport sink (input valid, input left_in, input right_in, input block_last,
                  output ready);

endinterface

// ===== rtl/core/spl_out_if.sv =====
// spl_out_if: result channel of the limiter, limited pair plus gain per transfer
// depends on spl_pkg

interface spl_out_if
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [COEFF_FRAC_BITS:0]      gain_now;
    logic                          block_last_out;

    modport source (output valid, output left_out, output right_out, output gain_now,
                    output block_last_out, input ready);
    modport sink (input valid, input left_out, input right_out, input gain_now,
                  input block_last_out, output ready);

endinterface

// ===== rtl/core/stereo_peak_limiter_top.sv =====
// stereo_peak_limiter_top: configuration registers and the front, queue and back
// depends on spl_pkg, spl_in_if, spl_out_if, spl_front, spl_queue, spl_back

// Stereo peak limiter. Each transfer on i_in carries one signed Q3.20 pair; each
// transfer on o_out returns the pair scaled by one smoothed Q1.24 gain, rounded half
// away from zero and clipped to +/- ceiling, together with that gain and the copied
// block marker. The target gain is 1.0, or ceiling / peak when the larger channel
// magnitude is above the ceiling; the gain moves toward it with the attack
// coefficient when falling and the release coefficient otherwise. The gain is never
// reset by the block marker. A pair above the ceiling is bound in the back end by the
// restoring divider that yields one quotient bit per cycle; a pair at or below the
// ceiling is bound by the four products that share one multiplier. Pairs are handled
// one at a time. A two-entry queue behind the input and a result register at the
// output let either side stall without stopping the other. The user must write the
// registers through i_cfg_we / i_cfg_idx / i_cfg_data only while no pair is in flight;
// the block does not enforce this. Index 0 is the ceiling, 1 the attack and 2 the
// release coefficient, coefficients above 1.0 are saturated to 1.0 and other indexes
// are ignored.

module stereo_peak_limiter_top
    import spl_pkg::*;
#(
    parameter int  SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int  COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
    localparam int CFG_W = (SAMPLE_BITS - 1 > COEFF_FRAC_BITS + 1) ? SAMPLE_BITS - 1
                                                                   : COEFF_FRAC_BITS + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    spl_in_if.sink                  i_in,
    spl_out_if.source               o_out
);

    localparam int GW = COEFF_FRAC_BITS + 1;

    // coefficient reset values rescaled from Q0.24 to the configured fraction width
    localparam int LSH = (COEFF_FRAC_BITS >= 24) ? COEFF_FRAC_BITS - 24 : 0;
    localparam int RSH = (COEFF_FRAC_BITS < 24) ? 24 - COEFF_FRAC_BITS : 0;
    localparam longint unsigned ONE_L  = 64'd1 << COEFF_FRAC_BITS;
    localparam longint unsigned MASK_L = (64'd2 << COEFF_FRAC_BITS) - 64'd1;
    localparam longint unsigned ATK_S  = ((64'(ATTACK_RESET_Q24) << LSH) >> RSH) & MASK_L;
    localparam longint unsigned REL_S  = ((64'(RELEASE_RESET_Q24) << LSH) >> RSH) & MASK_L;
    localparam logic [GW-1:0] ATK_RST  = GW'((ATK_S > ONE_L) ? ONE_L : ATK_S);
    localparam logic [GW-1:0] REL_RST  = GW'((REL_S > ONE_L) ? ONE_L : REL_S);
    localparam logic [SAMPLE_BITS-2:0] CEIL_RST = (SAMPLE_BITS-1)'(CEIL_RESET_Q20);
    localparam logic [GW-1:0] GAIN_ONE = {1'b1, {COEFF_FRAC_BITS{1'b0}}};

    // configuration registers
    logic [SAMPLE_BITS-2:0] r_ceiling;
    logic [GW-1:0]          r_attack;
    logic [GW-1:0]          r_release;
    logic [GW-1:0]          w_coef_raw;
    logic [GW-1:0]          w_coef_sat;

    // front to queue
    logic                   w_push;
    logic [SAMPLE_BITS-1:0] w_f_mag_l;
    logic [SAMPLE_BITS-1:0] w_f_mag_r;
    logic [SAMPLE_BITS-1:0] w_f_peak;
    t_work_flags            w_f_flags;

    // queue to back
    logic                   w_pop;
    logic [SAMPLE_BITS-1:0] w_q_mag_l;
    logic [SAMPLE_BITS-1:0] w_q_mag_r;
    logic [SAMPLE_BITS-1:0] w_q_peak;
    t_work_flags            w_q_flags;
    t_q_status              w_qstat;

    // coefficient writes keep the gain width and saturate at unity
    assign w_coef_raw = i_cfg_data[GW-1:0];
    assign w_coef_sat = (w_coef_raw > GAIN_ONE) ? GAIN_ONE : w_coef_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= CEIL_RST;
            r_attack  <= ATK_RST;
            r_release <= REL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CEILING: r_ceiling <= i_cfg_data[SAMPLE_BITS-2:0];
                REG_ATTACK:  r_attack  <= w_coef_sat;
                REG_RELEASE: r_release <= w_coef_sat;
                default:     r_ceiling <= r_ceiling;   // unknown index, no effect
            endcase
        end
    end

    // front: sign/magnitude split, peak and over-ceiling flag, takes the input transfer
    spl_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_in      (i_in),
        .i_ceiling (r_ceiling),
        .i_qstat   (w_qstat),
        .o_push    (w_push),
        .o_mag_l   (w_f_mag_l),
        .o_mag_r   (w_f_mag_r),
        .o_peak    (w_f_peak),
        .o_flags   (w_f_flags)
    );

    // queue: decouples input transfers from the back end's sequencing
    spl_queue #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .i_mag_l (w_f_mag_l),
        .i_mag_r (w_f_mag_r),
        .i_peak  (w_f_peak),
        .i_flags (w_f_flags),
        .o_mag_l (w_q_mag_l),
        .o_mag_r (w_q_mag_r),
        .o_peak  (w_q_peak),
        .o_flags (w_q_flags),
        .o_stat  (w_qstat)
    );

    // back: divider for the target, gain update, scaling, clip and result register
    spl_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ceiling (r_ceiling),
        .i_attack  (r_attack),
        .i_release (r_release),
        .i_qstat   (w_qstat),
        .i_mag_l   (w_q_mag_l),
        .i_mag_r   (w_q_mag_r),
        .i_peak    (w_q_peak),
        .i_flags   (w_q_flags),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/core/spl_front.sv =====
// spl_front: accepts sample pairs, splits sign and magnitude, finds the peak
// and flags pairs above the ceiling; depends on spl_pkg and spl_in_if

module spl_front
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    spl_in_if.sink                 i_in,
    input  logic [SAMPLE_BITS-2:0] i_ceiling,
    input  t_q_status              i_qstat,
    output logic                   o_push,
    output logic [SAMPLE_BITS-1:0] o_mag_l,
    output logic [SAMPLE_BITS-1:0] o_mag_r,
    output logic [SAMPLE_BITS-1:0] o_peak,
    output t_work_flags            o_flags
);

    logic [SAMPLE_BITS-1:0] w_raw_l;
    logic [SAMPLE_BITS-1:0] w_raw_r;

    assign w_raw_l = $unsigned(i_in.left_in);
    assign w_raw_r = $unsigned(i_in.right_in);

    // magnitude of the most negative code is 2^(n-1), still fits unsigned
    assign o_mag_l = w_raw_l[SAMPLE_BITS-1] ? (~w_raw_l + 1'b1) : w_raw_l;
    assign o_mag_r = w_raw_r[SAMPLE_BITS-1] ? (~w_raw_r + 1'b1) : w_raw_r;
    assign o_peak  = (o_mag_l > o_mag_r) ? o_mag_l : o_mag_r;

    assign o_flags.neg_l = w_raw_l[SAMPLE_BITS-1];
    assign o_flags.neg_r = w_raw_r[SAMPLE_BITS-1];
    assign o_flags.last  = i_in.block_last;
    assign o_flags.over  = (o_peak > {1'b0, i_ceiling});

    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && !i_qstat.full;

endmodule

// ===== rtl/core/spl_queue.sv =====
// spl_queue: short queue of classified pairs between front and back
// depends on spl_pkg

module spl_queue
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_pop,
    input  logic [SAMPLE_BITS-1:0] i_mag_l,
    input  logic [SAMPLE_BITS-1:0] i_mag_r,
    input  logic [SAMPLE_BITS-1:0] i_peak,
    input  t_work_flags            i_flags,
    output logic [SAMPLE_BITS-1:0] o_mag_l,
    output logic [SAMPLE_BITS-1:0] o_mag_r,
    output logic [SAMPLE_BITS-1:0] o_peak,
    output t_work_flags            o_flags,
    output t_q_status              o_stat
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int FW = $bits(t_work_flags);
    localparam int EW = 3 * SAMPLE_BITS + FW;

    logic [EW-1:0] r_mem [Q_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;
    logic [EW-1:0] w_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= {i_mag_l, i_mag_r, i_peak, i_flags};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign w_rd_data = r_mem[r_rd];
    assign o_mag_l   = w_rd_data[FW + 2*SAMPLE_BITS +: SAMPLE_BITS];
    assign o_mag_r   = w_rd_data[FW + SAMPLE_BITS +: SAMPLE_BITS];
    assign o_peak    = w_rd_data[FW +: SAMPLE_BITS];
    assign o_flags   = t_work_flags'(w_rd_data[FW-1:0]);

    assign o_stat.full  = (r_count == (AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== rtl/core/spl_div.sv =====
// spl_div: restoring divider, ceiling * 2^q / peak, one quotient bit per cycle
// expects numerator below divisor; depends on spl_pkg for defaults

module spl_div
    import spl_pkg::*;
#(
    parameter int QUOT_BITS = COEFF_FRAC_BITS_DEF,
    parameter int DEN_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DEN_BITS-2:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    output logic                 o_done,
    output logic [QUOT_BITS-1:0] o_quot
);

    localparam int CW = $clog2(QUOT_BITS + 1);

    logic [DEN_BITS-2:0]  r_rem;
    logic [DEN_BITS-1:0]  r_den;
    logic [QUOT_BITS-1:0] r_quot;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DEN_BITS-1:0]  w_shift;
    logic [DEN_BITS-1:0]  w_diff;
    logic                 w_ge;

    // remainder stays below the divisor, so the doubled value fits the divisor width
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= r_den);
    assign w_diff  = w_shift - r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= CW'(QUOT_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DEN_BITS-2:0] : w_shift[DEN_BITS-2:0];
                r_quot <= {r_quot[QUOT_BITS-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/spl_back.sv =====
// spl_back: gain smoothing and sample scaling, one shared multiplier, result register
// depends on spl_pkg, spl_div and spl_out_if

module spl_back
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [SAMPLE_BITS-2:0]   i_ceiling,
    input  logic [COEFF_FRAC_BITS:0] i_attack,
    input  logic [COEFF_FRAC_BITS:0] i_release,
    input  t_q_status                i_qstat,
    input  logic [SAMPLE_BITS-1:0]   i_mag_l,
    input  logic [SAMPLE_BITS-1:0]   i_mag_r,
    input  logic [SAMPLE_BITS-1:0]   i_peak,
    input  t_work_flags              i_flags,
    output logic                     o_pop,
    spl_out_if.source                o_out
);

    localparam int F  = COEFF_FRAC_BITS;
    localparam int GW = COEFF_FRAC_BITS + 1;
    localparam int MW = (SAMPLE_BITS > GW) ? SAMPLE_BITS : GW;
    localparam int PW = MW + GW;
    localparam logic [GW-1:0] GAIN_ONE = {1'b1, {F{1'b0}}};
    localparam logic [PW:0]   RND_HALF = {{(PW + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MA, S_MB, S_SUM, S_ML, S_MR, S_RR, S_OUT
    } t_state;

    t_state                 r_state;
    logic [SAMPLE_BITS-1:0] r_mag_l;
    logic [SAMPLE_BITS-1:0] r_mag_r;
    t_work_flags            r_flags;
    logic [GW-1:0]          r_target;
    logic [GW-1:0]          r_coef;
    logic [GW-1:0]          r_gain;
    logic [PW-1:0]          r_acc;
    logic [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0] r_res_l;
    logic [SAMPLE_BITS-1:0] r_res_r;
    logic [SAMPLE_BITS-1:0] r_out_l;
    logic [SAMPLE_BITS-1:0] r_out_r;
    logic [GW-1:0]          r_out_g;
    logic                   r_out_last;
    logic                   r_out_valid;

    logic [GW-1:0]          w_coef;
    logic [MW-1:0]          w_op_a;
    logic [GW-1:0]          w_op_b;
    logic [PW-1:0]          w_prod;
    logic [PW:0]            w_sum;
    logic [PW-F:0]          w_gain_wide;
    logic [GW-1:0]          w_gain_new;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [F-1:0]           w_quot;

    // round half away from zero on the magnitude, clip, restore the sign
    function automatic logic [SAMPLE_BITS-1:0] limit_one(
        input logic [PW-1:0]          prod,
        input logic                   neg,
        input logic [SAMPLE_BITS-2:0] ceil_v
    );
        logic [PW:0]            rnd;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] cl;
        rnd = {1'b0, prod} + RND_HALF;
        y   = rnd[F +: SAMPLE_BITS];
        cl  = {1'b0, ceil_v};
        if (y > cl) begin
            y = cl;
        end
        return neg ? (~y + 1'b1) : y;
    endfunction

    assign o_pop       = (r_state == S_IDLE) && !i_qstat.empty;
    assign w_div_start = o_pop && i_flags.over;

    spl_div #(
        .QUOT_BITS (COEFF_FRAC_BITS),
        .DEN_BITS  (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (i_ceiling),
        .i_den   (i_peak),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // attack when the gain has to fall, release otherwise
    assign w_coef = (r_target < r_gain) ? i_attack : i_release;

    always_comb begin
        case (r_state)
            S_MA: begin
                w_op_a = MW'(w_coef);
                w_op_b = r_gain;
            end
            S_MB: begin
                w_op_a = MW'(GAIN_ONE - r_coef);
                w_op_b = r_target;
            end
            S_ML: begin
                w_op_a = MW'(r_mag_l);
                w_op_b = r_gain;
            end
            S_MR: begin
                w_op_a = MW'(r_mag_r);
                w_op_b = r_gain;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod      = {{GW{1'b0}}, w_op_a} * {{MW{1'b0}}, w_op_b};
    assign w_sum       = {1'b0, r_acc} + {1'b0, r_prod} + RND_HALF;
    assign w_gain_wide = w_sum[PW:F];
    assign w_gain_new  = (w_gain_wide > (PW-F+1)'(GAIN_ONE)) ? GAIN_ONE
                                                             : w_gain_wide[GW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_ONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_mag_l  <= i_mag_l;
                        r_mag_r  <= i_mag_r;
                        r_flags  <= i_flags;
                        r_target <= GAIN_ONE;
                        r_state  <= i_flags.over ? S_DIV : S_MA;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_target <= {1'b0, w_quot};
                        r_state  <= S_MA;
                    end
                end
                S_MA: begin
                    r_coef  <= w_coef;
                    r_acc   <= w_prod;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_prod  <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_gain  <= w_gain_new;
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_prod  <= w_prod;
                    r_state <= S_MR;
                end
                S_MR: begin
                    r_res_l <= limit_one(r_prod, r_flags.neg_l, i_ceiling);
                    r_prod  <= w_prod;
                    r_state <= S_RR;
                end
                S_RR: begin
                    r_res_r <= limit_one(r_prod, r_flags.neg_r, i_ceiling);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_l     <= r_res_l;
                        r_out_r     <= r_res_r;
                        r_out_g     <= r_gain;
                        r_out_last  <= r_flags.last;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.left_out       = $signed(r_out_l);
    assign o_out.right_out      = $signed(r_out_r);
    assign o_out.gain_now       = r_out_g;
    assign o_out.block_last_out = r_out_last;

`ifndef SYNTHESIS
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_ONE)
        else $error("smoothed gain above unity");

    a_out_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_l) <= $signed({1'b0, i_ceiling}) &&
                         $signed(r_out_l) >= -$signed({1'b0, i_ceiling}) &&
                         $signed(r_out_r) <= $signed({1'b0, i_ceiling}) &&
                         $signed(r_out_r) >= -$signed({1'b0, i_ceiling})))
        else $error("result outside the ceiling");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished while the sequencer was not waiting");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result register loaded outside the output step");
`endif

endmodule

// ===== bench/stereo_peak_limiter_checker.sv =====
`timescale 1ns / 100ps
// stereo_peak_limiter_checker: watches both limiter channels and the register port,
// keeps its own gain and registers and compares every result transfer with its prediction
// depends on spl_pkg, spl_in_if, spl_out_if

module stereo_peak_limiter_checker
    import spl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COEFF_FRAC_BITS_DEF:0] i_cfg_data,
    spl_in_if                       i_pair,
    spl_out_if                      i_result,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int F  = COEFF_FRAC_BITS_DEF;
    localparam longint unsigned GAIN_ONE  = 64'd1 << F;
    localparam longint unsigned GAIN_HALF = GAIN_ONE >> 1;

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic [F:0]           gain;
        logic                 last;
    } t_limited_pair;

    logic [SB-2:0] ceiling_q;
    logic [F:0]    attack_q;
    logic [F:0]    release_q;
    logic [F:0]    gain_q;
    t_limited_pair limited_pairs[$];

    function automatic logic [F:0] saturate_coeff(input logic [F:0] v);
        return (v > GAIN_ONE) ? (F+1)'(GAIN_ONE) : v;
    endfunction

    function automatic longint unsigned magnitude(input logic signed [SB-1:0] x);
        longint signed v;
        v = x;
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // scale by the gain, round half away from zero, clip to the ceiling
    function automatic logic [SB-1:0] scale_and_clip(input logic signed [SB-1:0] x,
                                                     input logic [F:0] g);
        longint unsigned y;
        y = (magnitude(x) * g + GAIN_HALF) >> F;
        if (y > ceiling_q)
            y = ceiling_q;
        return x[SB-1] ? SB'(64'd0 - y) : SB'(y);
    endfunction

    // one smoothing step of the gain, then the limited pair under the new gain
    function automatic t_limited_pair advance_limiter(input logic signed [SB-1:0] l,
                                                      input logic signed [SB-1:0] r,
                                                      input logic last);
        longint unsigned peak;
        longint unsigned target;
        longint unsigned coeff;
        longint unsigned next_gain;
        t_limited_pair   res;
        peak = (magnitude(l) > magnitude(r)) ? magnitude(l) : magnitude(r);
        target = GAIN_ONE;
        if (peak > ceiling_q)
            target = (longint'(ceiling_q) << F) / peak;
        coeff = (target < gain_q) ? attack_q : release_q;
        next_gain = (coeff * gain_q + (GAIN_ONE - coeff) * target + GAIN_HALF) >> F;
        if (next_gain > GAIN_ONE)
            next_gain = GAIN_ONE;
        gain_q = next_gain[F:0];
        res.left  = scale_and_clip(l, gain_q);
        res.right = scale_and_clip(r, gain_q);
        res.gain  = gain_q;
        res.last  = last;
        return res;
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_limited_pair want;
        if (!i_rst_n) begin
            ceiling_q    = (SB-1)'(CEIL_RESET_Q20);
            attack_q     = saturate_coeff((F+1)'(ATTACK_RESET_Q24));
            release_q    = saturate_coeff((F+1)'(RELEASE_RESET_Q24));
            gain_q       = (F+1)'(GAIN_ONE);
            o_fail_count = 0;
            limited_pairs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CEILING: ceiling_q = i_cfg_data[SB-2:0];
                    REG_ATTACK:  attack_q  = saturate_coeff(i_cfg_data);
                    REG_RELEASE: release_q = saturate_coeff(i_cfg_data);
                    default: ;  // unknown index, no effect
                endcase
            end
            // results of older pairs first, the pair taken at this edge is queued after
            if (i_result.valid && i_result.ready) begin
                if (limited_pairs.size() == 0) begin
                    $display("%0t: unexpected result: left %0d right %0d gain %0d last %0b",
                             $time, i_result.left_out, i_result.right_out,
                             i_result.gain_now, i_result.block_last_out);
                    o_fail_count++;
                end else begin
                    want = limited_pairs.pop_front();
                    check_field("left_out", want.left, i_result.left_out);
                    check_field("right_out", want.right, i_result.right_out);
                    check_field("gain_now", want.gain, i_result.gain_now);
                    check_field("block_last_out", want.last, i_result.block_last_out);
                end
            end
            if (i_pair.valid && i_pair.ready)
                limited_pairs.push_back(advance_limiter(i_pair.left_in, i_pair.right_in,
                                                        i_pair.block_last));
        end
        o_pending = limited_pairs.size();
    end

endmodule

// ===== bench/stereo_peak_limiter_top_test.sv =====
`timescale 1ns / 100ps
// stereo_peak_limiter_top_test: drives sample pairs and register writes into the limiter,
// stalls both channels at random and reports the verdict
// depends on spl_pkg, spl_in_if, spl_out_if, stereo_peak_limiter_top, the checker

module stereo_peak_limiter_top_test;
    import spl_pkg::*;

    localparam int SB    = SAMPLE_BITS_DEF;
    localparam int F     = COEFF_FRAC_BITS_DEF;
    localparam int CFG_W = F + 1;  // the coefficients are the widest registers

    // index past the register list, writes to it must change nothing
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    localparam logic [F:0]    COEFF_ONE = (F+1)'(1 << F);  // gain of exactly 1.0
    localparam logic [F:0]    COEFF_ALL = '1;      // far above 1.0, saturates
    localparam logic [SB-1:0] MAX_POS   = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] MIN_NEG   = {1'b1, {(SB-1){1'b0}}};

    localparam int PHASES          = 10;
    localparam int PAIRS_PER_PHASE = 153;
    localparam int LONG_HOLD       = 80;          // receiver hold-off, fills the queue
    localparam int DRAIN_CYCLES    = 2 * (F + 9); // two divider passes of the back end
    localparam int STALL_LIMIT     = 2000;        // cycles without any transfer

    // loudness of a stretch of pairs
    typedef enum int {
        LEVEL_QUIET,
        LEVEL_LOUD,
        LEVEL_MIXED
    } t_level;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [CFG_W-1:0]        cfg_data;
    int                      fail_count;
    int                      pending;

    // bench-side view of the ceiling, used to aim samples around it
    logic [SB-2:0] cur_ceiling;
    // idling switches, flipped only while the block is idle
    logic          tx_idles;
    logic          rx_idles;
    logic          hold_req;

    spl_in_if  pair_ch ();
    spl_out_if result_ch ();

    stereo_peak_limiter_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (pair_ch),
        .o_out      (result_ch)
    );

    stereo_peak_limiter_checker limiter_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pair       (pair_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sample picker: loud stretches drive the gain down with the attack coefficient,
    // quiet ones let it recover with the release coefficient
    function automatic logic [SB-1:0] pick_sample(input t_level level);
        logic [SB-1:0] v;
        int            sel;
        case (level)
            LEVEL_QUIET: sel = $urandom_range(6, 9);
            LEVEL_LOUD:  sel = $urandom_range(0, 5);
            default:     sel = $urandom_range(0, 9);
        endcase
        case (sel)
            0:       v = MAX_POS;
            1:       v = MIN_NEG;
            2, 3, 4: v = SB'($urandom);  // any value, every bit toggles
            5:       v = SB'(cur_ceiling) + SB'($urandom_range(0, 2)) - SB'(1);  // at the edge
            6, 7:    v = SB'($urandom_range(0, cur_ceiling));  // at or under the ceiling
            8:       v = SB'($urandom_range(0, 255));
            default: v = '0;  // silence
        endcase
        if (sel >= 5 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // coefficient mix: zero, exactly one, above one, realistic smoothing, anything
    function automatic logic [F:0] pick_coeff();
        logic [F:0] c;
        case ($urandom_range(0, 5))
            0:       c = '0;
            1:       c = COEFF_ONE;
            2:       c = (F+1)'($urandom);
            3, 4:    c = COEFF_ONE - (F+1)'($urandom_range(1, 1 << 16));
            default: c = (F+1)'($urandom_range(0, 1 << F));
        endcase
        return c;
    endfunction

    // one pair transfer, with a random gap ahead of it when idling is on
    task automatic send_pair(input logic [SB-1:0] left, input logic [SB-1:0] right,
                             input logic last);
        int gap;
        @(negedge clk);
        if (tx_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            pair_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pair_ch.valid      <= 1'b1;
        pair_ch.left_in    <= left;
        pair_ch.right_in   <= right;
        pair_ch.block_last <= last;
        do @(posedge clk); while (!pair_ch.ready);
    endtask

    // stop offering pairs and wait until every result is back, so the block is idle
    task automatic drain();
        @(negedge clk);
        pair_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == REG_CEILING)
            cur_ceiling = data[SB-2:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver: random ready bursts, one long hold-off on request, none at the end
    initial begin : result_sink
        int   stall_left;
        int   hold_left;
        logic hold_taken;
        stall_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (rx_idles && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);  // stall starts now and goes on while stall_left counts down
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // a run with no transfer at all for too long is a hang
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (pair_ch.valid && pair_ch.ready)
                    || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int            sent;
        int            len;
        t_level        level;
        logic [CFG_W-1:0] ceil_d;
        logic [F:0]    atk;
        logic [F:0]    rel;

        // every input known from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_CEILING;
        cfg_data           = '0;
        pair_ch.valid      = 1'b0;
        pair_ch.left_in    = '0;
        pair_ch.right_in   = '0;
        pair_ch.block_last = 1'b0;
        cur_ceiling        = (SB-1)'(CEIL_RESET_Q20);
        tx_idles           = 1'b1;
        rx_idles           = 1'b1;
        hold_req           = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: ceiling 0.9, attack and release at their reset values
        send_pair('0, '0, 1'b0);                      // silence, target stays at unity
        send_pair(MAX_POS, '0, 1'b0);                 // one channel at full scale
        send_pair(MIN_NEG, MIN_NEG, 1'b1);            // most negative value on both sides
        send_pair('0, MIN_NEG, 1'b0);
        send_pair(SB'(CEIL_RESET_Q20), -SB'(CEIL_RESET_Q20), 1'b0);  // peak equal to ceiling
        send_pair(SB'(CEIL_RESET_Q20 + 1), SB'(100), 1'b0);          // just over it
        send_pair(SB'(1), -SB'(1), 1'b1);
        send_pair(MAX_POS, MIN_NEG, 1'b0);
        repeat (3) send_pair(SB'(1000), -SB'(1000), 1'b0);  // quiet, release pulls gain up

        // attack of zero jumps straight to the target, saturated release freezes the gain
        drain();
        write_reg(REG_ATTACK, '0);
        write_reg(REG_RELEASE, COEFF_ALL);
        write_reg(REG_UNUSED, CFG_W'($urandom));
        send_pair(MAX_POS, SB'(5), 1'b0);
        send_pair('0, '0, 1'b1);
        send_pair(-SB'(5), MAX_POS, 1'b0);

        // zero ceiling: any sound gives target zero and every output clips to zero
        drain();
        write_reg(REG_CEILING, '0);
        send_pair('0, '0, 1'b0);
        send_pair(SB'(1), -SB'(1), 1'b0);
        send_pair(MIN_NEG, MAX_POS, 1'b1);

        // random phases, each starts from an idle block with fresh register values
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin  // all-ones data masks down to the largest ceiling
                    ceil_d = '1;
                    atk    = '0;
                    rel    = COEFF_ONE;
                end
                1: begin  // smallest nonzero ceiling, limiting on nearly every pair
                    ceil_d = CFG_W'(1);
                    atk    = COEFF_ONE;
                    rel    = '0;
                end
                2: begin  // back to the power-up values
                    ceil_d = CFG_W'(CEIL_RESET_Q20);
                    atk    = (F+1)'(ATTACK_RESET_Q24);
                    rel    = (F+1)'(RELEASE_RESET_Q24);
                end
                3: begin
                    ceil_d = CFG_W'(1024);
                    atk    = COEFF_ALL;
                    rel    = COEFF_ALL;
                end
                default: begin
                    ceil_d = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(1, 1 << 21));
                    atk    = pick_coeff();
                    rel    = pick_coeff();
                end
            endcase
            write_reg(REG_CEILING, ceil_d);
            write_reg(REG_ATTACK, atk);
            write_reg(REG_RELEASE, rel);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, CFG_W'($urandom));

            // some phases run one side or both without gaps; the last phase has none
            tx_idles = (p != PHASES - 1) && (p % 3 != 1);
            rx_idles = (p != PHASES - 1) && (p % 3 != 2);
            hold_req = (p == 2);

            sent = 0;
            while (sent < PAIRS_PER_PHASE) begin
                level = t_level'($urandom_range(0, 2));
                len   = $urandom_range(1, 24);
                for (int k = 0; k < len && sent < PAIRS_PER_PHASE; k++) begin
                    send_pair(pick_sample(level), pick_sample(level),
                              1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end

        // all pairs taken: wait for the last results, then a little longer for strays
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0)
            $display("%0t: %0d results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/spl_pkg.sv
rtl/core/spl_in_if.sv
rtl/core/spl_out_if.sv
rtl/core/spl_front.sv
rtl/core/spl_queue.sv
rtl/core/spl_div.sv
rtl/core/spl_back.sv
rtl/core/stereo_peak_limiter_top.sv
bench/stereo_peak_limiter_checker.sv
bench/stereo_peak_limiter_top_test.sv
